/* rtl/crt_congruence_solver_assert.svh */
// Assertion macros used by the port-level checker file.
`ifndef CRT_CONGRUENCE_SOLVER_ASSERT_SVH
`define CRT_CONGRUENCE_SOLVER_ASSERT_SVH

// Same-cycle implication.
`define CRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/crt_pkg.sv */
// Shared types and constants of the congruence solver.
package crt_pkg;

    localparam int MAX_CONGRUENCES_DEF = 4;
    localparam int MODULUS_BITS_DEF    = 16;
    localparam int FIELD_W             = 16;
    localparam int PROD_W              = 64;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NOT_COPRIME = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW    = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] residue;
        logic [FIELD_W-1:0] modulus;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [PROD_W-1:0] solution;
        logic [PROD_W-1:0] combined_modulus;
        logic [1:0]        status;
    } result_t;

endpackage

/* rtl/crt_congruence_solver.sv */
// Congruence solver: loads residue/modulus words, then solves bit-serially.
// Loading: one word per cycle while idle; a word without last gives no result.
// Solve after last: the product of all moduli, then per entry the product of the other moduli,
// its reduction mod m, a subtractive Euclid inverse, modular multiplies and a running sum.
// The next list is taken once the solve ends; the bit-serial shift/add steps set the pace.
// Async active-low reset clears entry count, overflow flag, state and output valid.
module crt_congruence_solver #(
    parameter int MAX_CONGRUENCES = crt_pkg::MAX_CONGRUENCES_DEF,
    parameter int MODULUS_BITS    = crt_pkg::MODULUS_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  crt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output crt_pkg::result_t result
);

    localparam int IDX_W  = (MAX_CONGRUENCES > 1) ? $clog2(MAX_CONGRUENCES) : 1;
    localparam int CNT_W  = $clog2(MAX_CONGRUENCES + 1);
    localparam int FW     = crt_pkg::FIELD_W;
    localparam int PW     = crt_pkg::PROD_W;
    localparam int BIT_W  = $clog2(PW);
    localparam int FIX_W  = $clog2(FW);
    localparam logic [BIT_W-1:0] TOP_MBIT = BIT_W'(MODULUS_BITS - 1);
    localparam logic [BIT_W-1:0] TOP_PBIT = BIT_W'(PW - 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_TOT  = 12'b0000_0000_0010,
        S_SEL  = 12'b0000_0000_0100,
        S_OTH  = 12'b0000_0000_1000,
        S_RED  = 12'b0000_0001_0000,
        S_EUC  = 12'b0000_0010_0000,
        S_RRED = 12'b0000_0100_0000,
        S_MM   = 12'b0000_1000_0000,
        S_TADD = 12'b0001_0000_0000,
        S_TDBL = 12'b0010_0000_0000,
        S_SUM  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    function automatic logic [PW-1:0] add_mod_p(
        input logic [PW-1:0] a,
        input logic [PW-1:0] b,
        input logic [PW-1:0] m
    );
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [FW-1:0] add_mod_f(
        input logic [FW-1:0] a,
        input logic [FW-1:0] b,
        input logic [FW-1:0] m
    );
        logic [FW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[FW-1:0];
    endfunction

    logic [MODULUS_BITS-1:0] res_mem [MAX_CONGRUENCES];
    logic [MODULUS_BITS-1:0] mod_mem [MAX_CONGRUENCES];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             zero_reg, zero_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [BIT_W-1:0] bitc_reg, bitc_next;
    logic [PW-1:0]    prod_reg, prod_next, mult_reg, mult_next, oth_reg, oth_next;
    logic [PW-1:0]    total_reg, total_next, sol_reg, sol_next;
    logic [1:0]       status_reg, status_next;
    logic [FW-1:0]    m_reg, m_next, r_reg, r_next, rem_reg, rem_next;
    logic [FW-1:0]    r0_reg, r0_next, r1_reg, r1_next, s0_reg, s0_next, s1_reg, s1_next;
    logic             out_valid_reg, out_valid_next;
    crt_pkg::result_t out_reg, out_next;

    logic             accept;
    logic [IDX_W-1:0] rd_idx;
    logic [FW-1:0]    mod_rd, res_rd;
    logic [FIX_W-1:0] bi;
    logic             first_bit, last_j, last_i, bit_end;
    logic [PW-1:0]    mul_a, mul_p;
    logic [FW:0]      red_tmp;
    logic [FW-1:0]    red_rem;
    logic [FW-1:0]    mm_dbl;

    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (accept && (cnt_reg < CNT_W'(MAX_CONGRUENCES)))
        begin
            res_mem[cnt_reg[IDX_W-1:0]] <= item.residue[MODULUS_BITS-1:0];
            mod_mem[cnt_reg[IDX_W-1:0]] <= item.modulus[MODULUS_BITS-1:0];
        end
    end

    assign rd_idx    = (state_reg == S_SEL) ? i_reg : j_reg;
    assign mod_rd    = FW'(mod_mem[rd_idx]);
    assign res_rd    = FW'(res_mem[rd_idx]);
    assign bi        = bitc_reg[FIX_W-1:0];
    assign first_bit = (bitc_reg == TOP_MBIT);
    assign bit_end   = (bitc_reg == '0);
    assign last_j    = (CNT_W'(j_reg) == cnt_reg - CNT_W'(1));
    assign last_i    = (CNT_W'(i_reg) == cnt_reg - CNT_W'(1));
    assign mul_a     = first_bit ? prod_reg : mult_reg;
    assign mul_p     = (first_bit ? '0 : (prod_reg << 1)) + (mod_rd[bi] ? mul_a : '0);
    assign red_tmp   = (state_reg == S_RED) ? {rem_reg, mult_reg[PW-1]} : {rem_reg, r_reg[bi]};
    assign red_rem   = (red_tmp >= {1'b0, m_reg}) ? FW'(red_tmp - {1'b0, m_reg})
                                                  : red_tmp[FW-1:0];
    assign mm_dbl    = add_mod_f(r1_reg, r1_reg, m_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        zero_next      = zero_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        bitc_next      = bitc_reg;
        prod_next      = prod_reg;
        mult_next      = mult_reg;
        oth_next       = oth_reg;
        total_next     = total_reg;
        sol_next       = sol_reg;
        status_next    = status_reg;
        m_next         = m_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_reg < CNT_W'(MAX_CONGRUENCES))
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        state_next = S_TOT;
                        prod_next  = PW'(1);
                        j_next     = '0;
                        bitc_next  = TOP_MBIT;
                        zero_next  = 1'b0;
                    end
                end
            end
            S_TOT:
            begin
                prod_next = mul_p;
                mult_next = mul_a;
                if (mod_rd == '0)
                begin
                    zero_next = 1'b1;
                end
                if (bit_end)
                begin
                    if (last_j)
                    begin
                        total_next = mul_p;
                        if (ovf_reg)
                        begin
                            status_next = crt_pkg::STATUS_OVERFLOW;
                            state_next  = S_DONE;
                        end
                        else if (zero_reg || (mod_rd == '0))
                        begin
                            status_next = crt_pkg::STATUS_NOT_COPRIME;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            i_next     = '0;
                            sol_next   = '0;
                            state_next = S_SEL;
                        end
                    end
                    else
                    begin
                        j_next    = j_reg + IDX_W'(1);
                        bitc_next = TOP_MBIT;
                    end
                end
                else
                begin
                    bitc_next = bitc_reg - BIT_W'(1);
                end
            end
            S_SEL:
            begin
                m_next     = mod_rd;
                r_next     = res_rd;
                prod_next  = PW'(1);
                j_next     = '0;
                bitc_next  = TOP_MBIT;
                state_next = S_OTH;
            end
            S_OTH:
            begin
                if (j_reg == i_reg)
                begin
                    if (last_j)
                    begin
                        oth_next   = prod_reg;
                        mult_next  = prod_reg;
                        rem_next   = '0;
                        bitc_next  = TOP_PBIT;
                        state_next = S_RED;
                    end
                    else
                    begin
                        j_next    = j_reg + IDX_W'(1);
                        bitc_next = TOP_MBIT;
                    end
                end
                else
                begin
                    prod_next = mul_p;
                    mult_next = mul_a;
                    if (bit_end)
                    begin
                        if (last_j)
                        begin
                            oth_next   = mul_p;
                            mult_next  = mul_p;
                            rem_next   = '0;
                            bitc_next  = TOP_PBIT;
                            state_next = S_RED;
                        end
                        else
                        begin
                            j_next    = j_reg + IDX_W'(1);
                            bitc_next = TOP_MBIT;
                        end
                    end
                    else
                    begin
                        bitc_next = bitc_reg - BIT_W'(1);
                    end
                end
            end
            S_RED:
            begin
                rem_next  = red_rem;
                mult_next = mult_reg << 1;
                if (bit_end)
                begin
                    r0_next    = red_rem;
                    r1_next    = m_reg;
                    s0_next    = (m_reg == FW'(1)) ? '0 : FW'(1);
                    s1_next    = '0;
                    state_next = S_EUC;
                end
                else
                begin
                    bitc_next = bitc_reg - BIT_W'(1);
                end
            end
            S_EUC:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg == FW'(1))
                    begin
                        rem_next   = '0;
                        bitc_next  = TOP_MBIT;
                        state_next = S_RRED;
                    end
                    else
                    begin
                        status_next = crt_pkg::STATUS_NOT_COPRIME;
                        state_next  = S_DONE;
                    end
                end
                else if (r0_reg >= r1_reg)
                begin
                    r0_next = r0_reg - r1_reg;
                    s0_next = (s0_reg >= s1_reg) ? (s0_reg - s1_reg)
                                                 : FW'({1'b0, s0_reg} + {1'b0, m_reg}
                                                       - {1'b0, s1_reg});
                end
                else
                begin
                    r0_next = r1_reg;
                    r1_next = r0_reg;
                    s0_next = s1_reg;
                    s1_next = s0_reg;
                end
            end
            S_RRED:
            begin
                rem_next = red_rem;
                if (bit_end)
                begin
                    r1_next    = '0;
                    bitc_next  = TOP_MBIT;
                    state_next = S_MM;
                end
                else
                begin
                    bitc_next = bitc_reg - BIT_W'(1);
                end
            end
            S_MM:
            begin
                r1_next = s0_reg[bi] ? add_mod_f(mm_dbl, rem_reg, m_reg) : mm_dbl;
                if (bit_end)
                begin
                    prod_next  = '0;
                    mult_next  = (oth_reg == total_reg) ? '0 : oth_reg;
                    bitc_next  = TOP_MBIT;
                    state_next = S_TADD;
                end
                else
                begin
                    bitc_next = bitc_reg - BIT_W'(1);
                end
            end
            S_TADD:
            begin
                if (r1_reg[0])
                begin
                    prod_next = add_mod_p(prod_reg, mult_reg, total_reg);
                end
                state_next = S_TDBL;
            end
            S_TDBL:
            begin
                mult_next = add_mod_p(mult_reg, mult_reg, total_reg);
                r1_next   = r1_reg >> 1;
                if (bit_end)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    bitc_next  = bitc_reg - BIT_W'(1);
                    state_next = S_TADD;
                end
            end
            S_SUM:
            begin
                sol_next = add_mod_p(sol_reg, prod_reg, total_reg);
                if (last_i)
                begin
                    status_next = crt_pkg::STATUS_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_SEL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.solution         = (status_reg == crt_pkg::STATUS_OK)
                                                ? sol_reg : '0;
                    out_next.combined_modulus = total_reg;
                    out_next.status           = status_reg;
                    out_valid_next            = 1'b1;
                    cnt_next                  = '0;
                    ovf_next                  = 1'b0;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg   <= zero_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        bitc_reg   <= bitc_next;
        prod_reg   <= prod_next;
        mult_reg   <= mult_next;
        oth_reg    <= oth_next;
        total_reg  <= total_next;
        sol_reg    <= sol_next;
        status_reg <= status_next;
        m_reg      <= m_next;
        r_reg      <= r_next;
        rem_reg    <= rem_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        out_reg    <= out_next;
    end

endmodule

/* rtl/crt_checker.sv */
// Port-level checker for the congruence solver, bound to the top level.
`include "crt_congruence_solver_assert.svh"

module crt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input crt_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input crt_pkg::result_t result
);

    `CRT_ASSERT_NXT(a_out_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `CRT_ASSERT_IMP(a_err_zero, clk, rst_n, result_valid && (result.status != crt_pkg::STATUS_OK), result.solution == '0)
    `CRT_ASSERT_IMP(a_sol_range, clk, rst_n, result_valid && (result.status == crt_pkg::STATUS_OK), result.solution < result.combined_modulus)
    `CRT_ASSERT_NXT(a_busy_after_last, clk, rst_n, item_valid && !item_stall && item.last, item_stall)

endmodule

bind crt_congruence_solver crt_checker u_crt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* test/crt_solver_checker.sv */
// Checker for the congruence solver: predicts each result and compares it with the block.
module crt_solver_checker
    import crt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      errors,
    output int      pending,
    output int      results_seen,
    output int      ok_seen
);

    longint unsigned res_list [MAX_CONGRUENCES_DEF];
    longint unsigned mod_list [MAX_CONGRUENCES_DEF];
    int              list_len;
    bit              list_overflow;
    result_t         solutions_due [$];

    initial begin
        errors       = 0;
        pending      = 0;
        results_seen = 0;
        ok_seen      = 0;
        list_len     = 0;
        list_overflow = 0;
    end

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        errors++;
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    function automatic bit mod_inverse(input longint unsigned a, input longint unsigned m,
                                       output longint unsigned inv);
        longint r0, r1, s0, s1, q, t;
        r0 = longint'(a);
        r1 = longint'(m);
        s0 = 1;
        s1 = 0;
        inv = 0;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            t  = r0 - q * r1;
            r0 = r1;
            r1 = t;
            t  = s0 - q * s1;
            s0 = s1;
            s1 = t;
        end
        if (r0 != 1)
            return 0;
        s0 = s0 % longint'(m);
        if (s0 < 0)
            s0 = s0 + longint'(m);
        inv = longint'(s0);
        return 1;
    endfunction

    function automatic result_t solve_list();
        result_t         r;
        longint unsigned total, sol, others, inv, m, term;
        logic [127:0]    wide;
        logic [1:0]      st;
        total = 1;
        sol   = 0;
        st    = STATUS_OK;
        for (int i = 0; i < list_len; i++)
        begin
            total = total * mod_list[i];
            if (mod_list[i] == 0)
                st = STATUS_NOT_COPRIME;
        end
        if (st == STATUS_OK)
        begin
            for (int i = 0; i < list_len; i++)
            begin
                m = mod_list[i];
                others = 1;
                for (int j = 0; j < list_len; j++)
                    if (j != i)
                        others = others * mod_list[j];
                if (!mod_inverse(others % m, m, inv))
                begin
                    st = STATUS_NOT_COPRIME;
                    break;
                end
                term = ((res_list[i] % m) * inv) % m;
                wide = 128'(term) * 128'(others);
                term = longint'(wide % 128'(total));
                wide = 128'(sol) + 128'(term);
                sol  = longint'(wide % 128'(total));
            end
        end
        if (list_overflow)
            st = STATUS_OVERFLOW;
        if (st != STATUS_OK)
            sol = 0;
        r.solution         = sol;
        r.combined_modulus = total;
        r.status           = st;
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (solutions_due.size() == 0)
                begin
                    report("unexpected result", result.solution, 0);
                end
                else
                begin
                    want = solutions_due.pop_front();
                    if (want.status == STATUS_OK)
                        ok_seen++;
                    if (result.solution !== want.solution)
                        report("solution", result.solution, want.solution);
                    if (result.combined_modulus !== want.combined_modulus)
                        report("combined_modulus", result.combined_modulus,
                               want.combined_modulus);
                    if (result.status !== want.status)
                        report("status", result.status, want.status);
                end
            end
            if (item_valid && !item_stall)
            begin
                if (list_len < MAX_CONGRUENCES_DEF)
                begin
                    res_list[list_len] = item.residue;
                    mod_list[list_len] = item.modulus;
                    list_len++;
                end
                else
                    list_overflow = 1;
                if (item.last)
                begin
                    solutions_due.push_back(solve_list());
                    list_len      = 0;
                    list_overflow = 0;
                end
            end
            pending = solutions_due.size();
        end
    end

endmodule

/* test/tb_top.sv */
// Testbench top: drives congruence lists into the solver and gives the verdict.
module tb_top;
    import crt_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int errors, pending, results_seen, ok_seen;
    int words_sent;
    bit quiet;
    bit hold_req;

    crt_congruence_solver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    crt_solver_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .ok_seen      (ok_seen)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(240_000_000);
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side stall
    initial
    begin
        result_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall = 1;
                for (int c = 0; c < 600; c++)
                    @(negedge clk);
                hold_req = 0;
            end
            result_stall = !quiet && ($urandom_range(0, 99) < 21);
        end
    end

    // called just after a falling edge; returns just after the falling edge that follows acceptance
    task automatic put_word(input logic [15:0] r, input logic [15:0] m, input logic lst);
        if (!quiet && $urandom_range(0, 99) < 21)
        begin
            item_valid = 0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item.residue = r;
        item.modulus = m;
        item.last    = lst;
        item_valid   = 1;
        do
            @(posedge clk);
        while (item_stall);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic longint unsigned gcd(input longint unsigned a, input longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [15:0] pick_modulus();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom_range(1, 65535));
        return 16'($urandom_range(1, 255));
    endfunction

    // style 0: pairwise coprime, 1: any moduli, 2: more entries than capacity
    task automatic send_list(input int style);
        logic [15:0] mods [8];
        int          n;
        bit          clash;
        n = (style == 2) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
        begin
            for (int tries = 0; tries < 40; tries++)
            begin
                mods[k] = pick_modulus();
                clash = 0;
                if (style == 0)
                    for (int j = 0; j < k; j++)
                        if (gcd(mods[j], mods[k]) != 1)
                            clash = 1;
                if (!clash)
                    break;
            end
        end
        for (int k = 0; k < n; k++)
            put_word(16'($urandom), mods[k], k == n - 1);
        item_valid = 0;
    endtask

    initial
    begin
        int style;
        rst_n        = 0;
        item_valid   = 0;
        item         = '0;
        quiet        = 0;
        hold_req     = 0;
        words_sent   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        put_word(16'hffff, 16'hffff, 1);
        put_word(16'h0000, 16'h0001, 1);
        put_word(16'h1234, 16'h0001, 0);
        put_word(16'h0007, 16'h000b, 1);
        put_word(16'hfffe, 16'hffff, 0);
        put_word(16'hffff, 16'hfffe, 1);
        put_word(16'h0004, 16'h0006, 0);
        put_word(16'h0007, 16'h000a, 1);
        put_word(16'h0003, 16'h0000, 0);
        put_word(16'h0002, 16'h0005, 1);
        put_word(16'h0001, 16'h0003, 0);
        put_word(16'h0002, 16'h0005, 0);
        put_word(16'h0003, 16'h0007, 0);
        put_word(16'h0004, 16'h000b, 0);
        put_word(16'h0005, 16'h000d, 1);
        put_word(16'hffff, 16'hfff1, 0);
        put_word(16'h8000, 16'hffef, 0);
        put_word(16'h7fff, 16'hffd9, 0);
        put_word(16'h0000, 16'hfffb, 1);
        put_word(16'h5555, 16'h0002, 0);
        put_word(16'haaaa, 16'h0004, 1);
        item_valid = 0;

        // drain before the random part
        while (pending != 0)
            @(negedge clk);

        hold_req = 1;
        while (words_sent < 1600)
        begin
            quiet = (words_sent > 700 && words_sent < 900);
            style = $urandom_range(0, 99);
            send_list(style < 65 ? 0 : (style < 90 ? 1 : 2));
        end
        quiet = 0;

        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("sent %0d words, checked %0d results, %0d of them solved with status ok",
                 words_sent, results_seen, ok_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/crt_pkg.sv
rtl/crt_congruence_solver.sv
rtl/crt_checker.sv
test/crt_solver_checker.sv
test/tb_top.sv
